// ===== sv/qrsd_pkg.sv =====
package qrsd_pkg;

    localparam int unsigned SAMPLE_W = 8;
    localparam int unsigned DIFF_W   = 9;
    localparam int unsigned PROD_W   = 24;
    localparam int unsigned HALF_W   = 16;
    localparam int unsigned THR_W    = 24;
    localparam int unsigned REFR_W   = 8;
    localparam int unsigned RATE_W   = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 24;
    localparam int unsigned OUT_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_DETECT_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REFRACTORY_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_CONSTANT     = 2'd2;

    localparam logic [THR_W-1:0]  RST_DETECT_THRESHOLD  = 24'd128;
    localparam logic [REFR_W-1:0] RST_REFRACTORY_LENGTH = 8'd40;
    localparam logic [RATE_W-1:0] RST_RATE_CONSTANT     = 16'd12000;

    localparam logic [RATE_W-1:0] INTERVAL_MAX = 16'hFFFF;
    localparam logic [PROD_W-1:0] CLIP_MAX     = 24'd255;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_MUL_AB = 6'b000010,
        ST_MUL_C  = 6'b000100,
        ST_DECIDE = 6'b001000,
        ST_DIV    = 6'b010000,
        ST_FINISH = 6'b100000
    } t_state;

    typedef struct packed {
        logic              start;
        logic [RATE_W-1:0] dividend;
        logic [RATE_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [RATE_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ===== sv/qrsd_div.sv =====
module qrsd_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  qrsd_pkg::t_div_req  i_req,
    output qrsd_pkg::t_div_rsp  o_rsp
);

    localparam int unsigned W     = qrsd_pkg::RATE_W;
    localparam int unsigned CNT_W = $clog2(W + 1);

    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_quo;
    logic [W-1:0]     r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [W:0]       rem_sh;
    logic [W:0]       rem_sub;
    logic             ge;

    // one quotient bit per cycle, restoring
    assign rem_sh  = {r_rem, r_quo[W-1]};
    assign ge      = rem_sh >= {1'b0, r_dvs};
    assign rem_sub = rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_req.dividend;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem <= ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
                r_quo <= {r_quo[W-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ===== sv/qrs_detector_heart_rate_top.sv =====
// QRS detector with heart-rate readout (multiplication of backward differences).
// Input stream: one 8-bit ECG sample per item on s_axis_*.
// Output stream: one result per sample on m_axis_*; tdata carries the clipped
// difference product, the refractory indicator and the heart rate, tuser
// flags a detected beat (heart rate is zero otherwise).
// Configuration: write enable, register index and data, taken on any cycle
// while the block is idle: 0 threshold, 1 refractory length, 2 rate constant.
// The block does not enforce this. An accepted sample passes ST_MUL_AB, ST_MUL_C,
// ST_DECIDE and ST_FINISH, which registers the result; on a beat, ST_DIV lies
// before ST_FINISH and waits for the 16-step bit-serial divider that forms the
// heart rate. s_axis_tready returns in the same cycle as the result is registered.
// The two multiplications of the 8-bit magnitudes share one 16x8 multiplier, in
// ST_MUL_AB and ST_MUL_C. A finished result sits in the output register; the next
// sample is taken and worked on meanwhile, and its result waits until the receiver
// takes the earlier one, so a stalled receiver eventually stalls the input.
// Synchronous reset clears the history, the counters and the output valid,
// and loads the register defaults (threshold 128, length 40, constant 12000).
module qrs_detector_heart_rate_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] product_clipped, [8] indicator_on,
                                        // [24:9] heart_rate, [31:25] zero
    output logic        m_axis_tuser,   // [0] beat
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    localparam int unsigned SW = qrsd_pkg::SAMPLE_W;
    localparam int unsigned DW = qrsd_pkg::DIFF_W;
    localparam int unsigned PW = qrsd_pkg::PROD_W;
    localparam int unsigned HW = qrsd_pkg::HALF_W;
    localparam int unsigned RW = qrsd_pkg::RATE_W;
    localparam int unsigned LW = qrsd_pkg::REFR_W;

    qrsd_pkg::t_state r_state;

    logic [qrsd_pkg::THR_W-1:0] r_thr;
    logic [LW-1:0]              r_len;
    logic [RW-1:0]              r_rconst;

    logic [SW-1:0] r_prev;
    logic [DW-1:0] r_d0;
    logic [DW-1:0] r_d1;
    logic [DW-1:0] r_d2;
    logic [LW-1:0] r_refr;
    logic [RW-1:0] r_intv;
    logic [PW-1:0] r_prod;
    logic          r_beat;
    logic [RW-1:0] r_rate;

    logic          r_out_valid;
    logic [SW-1:0] r_out_prod;
    logic          r_out_beat;
    logic          r_out_ind;
    logic [RW-1:0] r_out_rate;

    logic [DW-1:0] diff_new;
    logic [SW-1:0] mag0;
    logic [SW-1:0] mag1;
    logic [SW-1:0] mag2;
    logic          all_pos;
    logic          all_neg;
    logic [HW-1:0] mul_a;
    logic [SW-1:0] mul_b;
    logic [PW-1:0] mul_p;
    logic [LW:0]   refr_next;
    logic          out_free;

    qrsd_pkg::t_div_req div_req;
    qrsd_pkg::t_div_rsp div_rsp;

    function automatic logic [SW-1:0] mag(input logic [DW-1:0] v);
        logic [DW-1:0] n;
        n = v[DW-1] ? (~v + 1'b1) : v;
        return n[SW-1:0];
    endfunction

    assign diff_new = {1'b0, s_axis_tdata} - {1'b0, r_prev};
    assign mag0 = mag(r_d0);
    assign mag1 = mag(r_d1);
    assign mag2 = mag(r_d2);
    assign all_pos = !r_d0[DW-1] && !r_d1[DW-1] && !r_d2[DW-1]
                     && (r_d0 != '0) && (r_d1 != '0) && (r_d2 != '0);
    assign all_neg = r_d0[DW-1] && r_d1[DW-1] && r_d2[DW-1];

    // shared multiplier: |d0|*|d1| first, then that times |d2|
    always_comb begin
        if (r_state == qrsd_pkg::ST_MUL_C) begin
            mul_a = r_prod[HW-1:0];
            mul_b = mag2;
        end else begin
            mul_a = {{(HW-SW){1'b0}}, mag0};
            mul_b = mag1;
        end
    end
    assign mul_p = PW'(mul_a) * PW'(mul_b);

    assign refr_next = {1'b0, r_refr} + 1'b1;
    assign out_free  = !r_out_valid || m_axis_tready;

    assign div_req.start    = (r_state == qrsd_pkg::ST_DECIDE) && (r_refr == '0)
                              && (r_prod > r_thr);
    assign div_req.dividend = r_rconst;
    assign div_req.divisor  = r_intv;

    qrsd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr    <= qrsd_pkg::RST_DETECT_THRESHOLD;
            r_len    <= qrsd_pkg::RST_REFRACTORY_LENGTH;
            r_rconst <= qrsd_pkg::RST_RATE_CONSTANT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                qrsd_pkg::CFG_DETECT_THRESHOLD:  r_thr    <= i_cfg_data;
                qrsd_pkg::CFG_REFRACTORY_LENGTH: r_len    <= i_cfg_data[LW-1:0];
                qrsd_pkg::CFG_RATE_CONSTANT:     r_rconst <= i_cfg_data[RW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= qrsd_pkg::ST_IDLE;
            r_prev      <= '0;
            r_d0        <= '0;
            r_d1        <= '0;
            r_d2        <= '0;
            r_refr      <= '0;
            r_intv      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == qrsd_pkg::ST_FINISH) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                qrsd_pkg::ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_d2   <= r_d1;
                        r_d1   <= r_d0;
                        r_d0   <= diff_new;
                        r_prev <= s_axis_tdata;
                        if (r_intv != qrsd_pkg::INTERVAL_MAX) begin
                            r_intv <= r_intv + 1'b1;
                        end
                        r_state <= qrsd_pkg::ST_MUL_AB;
                    end
                end
                qrsd_pkg::ST_MUL_AB: begin
                    r_prod  <= mul_p;
                    r_state <= qrsd_pkg::ST_MUL_C;
                end
                qrsd_pkg::ST_MUL_C: begin
                    r_prod  <= (all_pos || all_neg) ? mul_p : '0;
                    r_state <= qrsd_pkg::ST_DECIDE;
                end
                qrsd_pkg::ST_DECIDE: begin
                    r_rate <= '0;
                    if (r_refr != '0) begin
                        r_refr  <= (refr_next >= {1'b0, r_len}) ? '0 : refr_next[LW-1:0];
                        r_beat  <= 1'b0;
                        r_state <= qrsd_pkg::ST_FINISH;
                    end else if (r_prod > r_thr) begin
                        r_refr  <= (r_len <= LW'(1)) ? '0 : LW'(1);
                        r_beat  <= 1'b1;
                        r_intv  <= '0;
                        r_state <= qrsd_pkg::ST_DIV;
                    end else begin
                        r_beat  <= 1'b0;
                        r_state <= qrsd_pkg::ST_FINISH;
                    end
                end
                qrsd_pkg::ST_DIV: begin
                    if (div_rsp.done) begin
                        r_rate  <= div_rsp.quotient;
                        r_state <= qrsd_pkg::ST_FINISH;
                    end
                end
                qrsd_pkg::ST_FINISH: begin
                    if (out_free) begin
                        r_out_prod  <= (r_prod > qrsd_pkg::CLIP_MAX) ? '1 : r_prod[SW-1:0];
                        r_out_beat  <= r_beat;
                        r_out_ind   <= (r_refr != '0);
                        r_out_rate  <= r_rate;
                        r_state     <= qrsd_pkg::ST_IDLE;
                    end
                end
                default: r_state <= qrsd_pkg::ST_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == qrsd_pkg::ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_beat;
    assign m_axis_tdata  = {{(qrsd_pkg::OUT_DATA_W - RW - 1 - SW){1'b0}},
                            r_out_rate, r_out_ind, r_out_prod};

endmodule
